// ===== rtl/drt_pkg.sv =====
package drt_pkg;

	localparam int TARGET_BITS_DEF = 256;

	// quotient bits resolved by each divider cell
	localparam int DIV_STEPS = 4;

	// (I+1)*spacing <= timespan + spacing < 2^25
	localparam int DIVISOR_W = 25;
	// (I-1)*spacing, two's complement, -65535 .. 2^24
	localparam int BASE_W = 26;
	// |(I-1)*spacing + 2*actual| < 2^34
	localparam int MAG_W = 34;
	localparam int MULT_W = 35;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_HIST    = 3'd0,
		REG_SPACING     = 3'd1,
		REG_TIMESPAN    = 3'd2,
		REG_START_LIMIT = 3'd3,
		REG_LIMIT_SHIFT = 3'd4
	} reg_idx_t;

	localparam logic [1:0] OUT_COMPUTED = 2'd0;
	localparam logic [1:0] OUT_START    = 2'd1;
	localparam logic [1:0] OUT_CLAMPED  = 2'd2;

	localparam logic [15:0] RST_MIN_HIST    = 16'd24;
	localparam logic [15:0] RST_SPACING     = 16'd60;
	localparam logic [23:0] RST_TIMESPAN    = 24'd1200;
	localparam logic [31:0] RST_START_LIMIT = 32'd504365055;
	localparam logic [7:0]  RST_LIMIT_SHIFT = 8'd20;

	// constants derived from spacing and timespan
	typedef struct packed {
		logic                 busy;
		logic [BASE_W-1:0]    base;
		logic [DIVISOR_W-1:0] divisor;
	} derived_t;

endpackage

// ===== rtl/drt_setup.sv =====
module drt_setup
	import drt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        kick,
	input  logic [15:0] spacing,
	input  logic [23:0] timespan,
	output derived_t    derived
);

	typedef enum logic [2:0] {ST_LOAD, ST_DIV, ST_MUL, ST_SUM, ST_DONE} st_t;

	st_t                  state_q;
	logic [15:0]          sp_q;
	logic [23:0]          work_q;
	logic [15:0]          rem_q;
	logic [4:0]           cnt_q;
	logic [23:0]          isp_q;
	logic [BASE_W-1:0]    base_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [16:0]          trial;
	logic                 ge;

	always_comb begin
		trial = {rem_q, work_q[23]};
		ge    = trial >= {1'b0, sp_q};
	end

	// restoring division timespan / spacing, one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (kick) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					sp_q    <= (spacing == 16'd0) ? 16'd1 : spacing;
					work_q  <= timespan;
					rem_q   <= '0;
					cnt_q   <= 5'd23;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= ge ? 16'(trial - {1'b0, sp_q}) : trial[15:0];
					work_q <= {work_q[22:0], ge};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// I*spacing never exceeds timespan
					isp_q   <= 24'(40'(work_q) * 40'(sp_q));
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					base_q  <= {2'b00, isp_q} - {10'd0, sp_q};
					div_q   <= {1'b0, isp_q} + {9'd0, sp_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
				end
			endcase
		end
	end

	assign derived.busy    = (state_q != ST_DONE);
	assign derived.base    = base_q;
	assign derived.divisor = div_q;

endmodule

// ===== rtl/drt_front.sv =====
module drt_front
	import drt_pkg::*;
#(
	parameter int TB = TARGET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          has_last,
	input  logic [30:0]   last_height,
	input  logic [31:0]   last_bits,
	input  logic [31:0]   last_time,
	input  logic [31:0]   prev_time,
	input  logic [15:0]   min_hist,
	input  derived_t      derived,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [TB-1:0] out_prod,
	output logic          out_start
);

	localparam int NL = (TB + 31) / 32;
	localparam int PW = NL * 32;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !derived.busy;

	// stage 1: decode target, form multiplier
	logic [7:0]         size;
	logic [22:0]        mant;
	logic [4:0]         sh_r;
	logic [10:0]        sh_l;
	logic [TB-1:0]      mant_w;
	logic [TB-1:0]      dec;
	logic [32:0]        diff;
	logic [31:0]        act;
	logic [MULT_W-1:0]  m;
	logic               start;

	always_comb begin
		size   = last_bits[31:24];
		mant   = last_bits[22:0];
		sh_r   = 5'((3 - int'(size[1:0])) * 8);
		sh_l   = 11'((int'(size) - 3) * 8);
		mant_w = TB'(mant);
		dec    = (size <= 8'd3) ? (mant_w >> sh_r) : (mant_w << sh_l);
		diff   = {1'b0, last_time} - {1'b0, prev_time};
		act    = diff[32] ? 32'd1 : diff[31:0];
		m      = {{(MULT_W-BASE_W){derived.base[BASE_W-1]}}, derived.base}
		         + {2'b00, act, 1'b0};
		start  = !has_last || (last_height == 31'd0)
		         || (last_height < {15'd0, min_hist});
	end

	logic [TB-1:0]    t_s1;
	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1, start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1     <= dec;
			neg_s1   <= m[MULT_W-1];
			mag_s1   <= m[MULT_W-1] ? MAG_W'(~m + 1'b1) : m[MAG_W-1:0];
			start_s1 <= start;
		end
	end

	// stage 2: limb products against the low 32 multiplier bits, plus terms for bits 32 and 33
	logic [PW-1:0]    tpad;
	logic [63:0]      pp [NL];
	logic [PW+31:0]   ev, od;
	logic [TB-1:0]    th;

	always_comb begin
		tpad = PW'(t_s1);
		ev   = '0;
		od   = '0;
		for (int i = 0; i < NL; i++) begin
			pp[i] = 64'(tpad[32*i +: 32]) * 64'(mag_s1[31:0]);
			if (i % 2 == 0) begin
				ev[32*i +: 64] = pp[i];
			end else begin
				od[32*i +: 64] = pp[i];
			end
		end
		th = (mag_s1[32] ? t_s1 : '0) + (mag_s1[33] ? (t_s1 << 1) : '0);
	end

	logic [TB-1:0] ev_s2, od_s2, th_s2;
	logic          neg_s2, start_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ev_s2    <= ev[TB-1:0];
			od_s2    <= od[TB-1:0];
			th_s2    <= th;
			neg_s2   <= neg_s1;
			start_s2 <= start_s1;
		end
	end

	// stage 3, 4: partial sums, stage 5: sign
	logic [TB-1:0] sum_s3, th_s3, p_s4;
	logic          neg_s3, start_s3, neg_s4, start_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sum_s3   <= ev_s2 + od_s2;
			th_s3    <= th_s2;
			neg_s3   <= neg_s2;
			start_s3 <= start_s2;
		end
		if (en4) begin
			p_s4     <= sum_s3 + (th_s3 << 32);
			neg_s4   <= neg_s3;
			start_s4 <= start_s3;
		end
		if (en5) begin
			out_prod  <= neg_s4 ? (~p_s4 + 1'b1) : p_s4;
			out_start <= start_s4;
		end
	end

	assign out_valid = v_s5;

endmodule

// ===== rtl/drt_div_cell.sv =====
module drt_div_cell
	import drt_pkg::*;
#(
	parameter int W = TARGET_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DIVISOR_W-1:0] in_rem,
	input  logic [W-1:0]         in_work,
	input  logic                 in_start,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIVISOR_W-1:0] out_rem,
	output logic [W-1:0]         out_work,
	output logic                 out_start
);

	logic                 v_q;
	logic [DIVISOR_W-1:0] r;
	logic [W-1:0]         w;
	logic [DIVISOR_W:0]   trial;
	logic                 ge;

	// shift dividend bits into the remainder, quotient bits into the low end
	always_comb begin
		r = in_rem;
		w = in_work;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {r, w[W-1]};
			ge    = trial >= {1'b0, divisor};
			r     = ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
			w     = {w[W-2:0], ge};
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_rem   <= r;
			out_work  <= w;
			out_start <= in_start;
		end
	end

	assign out_valid = v_q;

endmodule

// ===== rtl/drt_back.sv =====
module drt_back
	import drt_pkg::*;
#(
	parameter int TB = TARGET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [TB-1:0] quot,
	input  logic          in_start,
	input  logic [7:0]    limit_shift,
	input  logic [31:0]   start_compact,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   next_bits,
	output logic [1:0]    outcome
);

	localparam int NL = (TB + 31) / 32;
	localparam int PW = NL * 32;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_o;

	assign en_o     = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// stage 1: clamp
	logic [TB-1:0] limit;
	logic          clamp;

	always_comb begin
		limit = {TB{1'b1}} >> limit_shift;
		clamp = (quot == '0) || (quot > limit);
	end

	logic [TB-1:0] r_s1;
	logic [1:0]    oc_s1;
	logic          start_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1     <= clamp ? limit : quot;
			oc_s1    <= in_start ? OUT_START : (clamp ? OUT_CLAMPED : OUT_COMPUTED);
			start_s1 <= in_start;
		end
	end

	// stage 2: top non-zero byte in each word
	logic [PW-1:0] rp1;
	logic [NL-1:0] wnz;
	logic [1:0]    wtop [NL];

	always_comb begin
		rp1 = PW'(r_s1);
		for (int i = 0; i < NL; i++) begin
			wnz[i] = |rp1[32*i +: 32];
			priority if (rp1[32*i+24 +: 8] != 8'd0) begin
				wtop[i] = 2'd3;
			end else if (rp1[32*i+16 +: 8] != 8'd0) begin
				wtop[i] = 2'd2;
			end else if (rp1[32*i+8 +: 8] != 8'd0) begin
				wtop[i] = 2'd1;
			end else begin
				wtop[i] = 2'd0;
			end
		end
	end

	logic [TB-1:0] r_s2;
	logic [NL-1:0] wnz_s2;
	logic [1:0]    wtop_s2 [NL];
	logic [1:0]    oc_s2;
	logic          start_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			r_s2     <= r_s1;
			wnz_s2   <= wnz;
			wtop_s2  <= wtop;
			oc_s2    <= oc_s1;
			start_s2 <= start_s1;
		end
	end

	// stage 3: byte length
	logic [5:0] ns;

	always_comb begin
		ns = 6'd0;
		for (int i = 0; i < NL; i++) begin
			if (wnz_s2[i]) begin
				ns = 6'(4 * i) + 6'(wtop_s2[i]) + 6'd1;
			end
		end
	end

	logic [TB-1:0] r_s3;
	logic [5:0]    ns_s3;
	logic [1:0]    oc_s3;
	logic          start_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			r_s3     <= r_s2;
			ns_s3    <= ns;
			oc_s3    <= oc_s2;
			start_s3 <= start_s2;
		end
	end

	// output stage: mantissa extraction, keep clear of the sign bit
	logic [PW-1:0] rp3;
	logic [4:0]    sh_up;
	logic [7:0]    sh_dn;
	logic [23:0]   c;
	logic [5:0]    ns_f;

	always_comb begin
		rp3   = PW'(r_s3);
		sh_up = 5'((3 - int'(ns_s3)) * 8);
		sh_dn = 8'((int'(ns_s3) - 3) * 8);
		if (ns_s3 <= 6'd3) begin
			c = rp3[23:0] << sh_up;
		end else begin
			c = 24'(rp3 >> sh_dn);
		end
		ns_f = ns_s3;
		if (c[23]) begin
			c    = c >> 8;
			ns_f = ns_s3 + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			next_bits <= start_s3 ? start_compact : {2'b00, ns_f, c};
			outcome   <= oc_s3;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/difficulty_retarget.sv =====
// Difficulty retarget: one transaction in, one compact target out. The datapath is fully
// pipelined and takes a new transaction every cycle unless out_ready or setup holds it; the
// quotient comes from a chain of divider cells that each resolve four quotient bits.
// After reset, and after every write to target_spacing or target_timespan, in_ready stays
// low while the interval and the divisor are derived by a bit-serial divider. The user must
// write configuration only while no transaction is in flight; the block does not enforce it.
module difficulty_retarget
	import drt_pkg::*;
#(
	parameter int TARGET_BITS = TARGET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  has_last,
	input  logic [30:0]           last_height,
	input  logic [31:0]           last_bits,
	input  logic [31:0]           last_time,
	input  logic [31:0]           prev_time,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           next_bits,
	output logic [1:0]            outcome
);

	localparam int NCELL = (TARGET_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DW    = NCELL * DIV_STEPS;

	logic [15:0] min_hist_q;
	logic [15:0] spacing_q;
	logic [23:0] timespan_q;
	logic [31:0] start_limit_q;
	logic [7:0]  limit_shift_q;
	logic        kick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hist_q    <= RST_MIN_HIST;
			spacing_q     <= RST_SPACING;
			timespan_q    <= RST_TIMESPAN;
			start_limit_q <= RST_START_LIMIT;
			limit_shift_q <= RST_LIMIT_SHIFT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_HIST:    min_hist_q    <= cfg_wdata[15:0];
				REG_SPACING:     spacing_q     <= cfg_wdata[15:0];
				REG_TIMESPAN:    timespan_q    <= cfg_wdata[23:0];
				REG_START_LIMIT: start_limit_q <= cfg_wdata;
				REG_LIMIT_SHIFT: limit_shift_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign kick = cfg_we && (cfg_index == REG_SPACING || cfg_index == REG_TIMESPAN);

	derived_t derived;

	drt_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.kick     (kick),
		.spacing  (spacing_q),
		.timespan (timespan_q),
		.derived  (derived)
	);

	logic                   f_valid, f_ready, f_start;
	logic [TARGET_BITS-1:0] f_prod;

	drt_front #(.TB(TARGET_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.has_last    (has_last),
		.last_height (last_height),
		.last_bits   (last_bits),
		.last_time   (last_time),
		.prev_time   (prev_time),
		.min_hist    (min_hist_q),
		.derived     (derived),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.out_prod    (f_prod),
		.out_start   (f_start)
	);

	logic                 c_valid [NCELL+1];
	logic                 c_ready [NCELL+1];
	logic                 c_start [NCELL+1];
	logic [DIVISOR_W-1:0] c_rem   [NCELL+1];
	logic [DW-1:0]        c_work  [NCELL+1];

	assign c_valid[0] = f_valid;
	assign f_ready    = c_ready[0];
	assign c_start[0] = f_start;
	assign c_rem[0]   = '0;
	assign c_work[0]  = DW'(f_prod);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		drt_div_cell #(.W(DW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[g]),
			.in_ready  (c_ready[g]),
			.in_rem    (c_rem[g]),
			.in_work   (c_work[g]),
			.in_start  (c_start[g]),
			.divisor   (derived.divisor),
			.out_valid (c_valid[g+1]),
			.out_ready (c_ready[g+1]),
			.out_rem   (c_rem[g+1]),
			.out_work  (c_work[g+1]),
			.out_start (c_start[g+1])
		);
	end

	drt_back #(.TB(TARGET_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (c_valid[NCELL]),
		.in_ready      (c_ready[NCELL]),
		.quot          (c_work[NCELL][TARGET_BITS-1:0]),
		.in_start      (c_start[NCELL]),
		.limit_shift   (limit_shift_q),
		.start_compact (start_limit_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_bits     (next_bits),
		.outcome       (outcome)
	);

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		derived.busy |-> !in_ready)
		else $error("transaction accepted while derived constants pending");

	a_kick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kick |=> derived.busy)
		else $error("spacing or timespan write did not restart setup");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUT_COMPUTED || outcome == OUT_START
		               || outcome == OUT_CLAMPED))
		else $error("bad outcome code");

	a_start_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_START |-> next_bits == start_limit_q)
		else $error("start limit not returned");

	a_computed_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_COMPUTED |-> next_bits[23:0] != 24'd0 && !next_bits[23])
		else $error("computed compact value malformed");

endmodule
